@@ hdl/psch_pkg.sv @@
// shared types and constants for the nonpreemptive priority scheduler
// no dependencies; imported by psch_cell and the top level
package psch_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int RUN_W       = 16;
    localparam int PRIO_W      = 8;
    localparam int QCOUNT_W    = 5;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [RUN_W-1:0]  run;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // per-tick control broadcast to every queue cell
    typedef struct packed {
        logic   tick;     // a tick is processed this cycle
        logic   ins;      // the arrival goes into the queue
        logic   pop;      // the head leaves the queue
        entry_t arrival;
    } cell_ctrl_t;

endpackage

@@ hdl/nonpreemptive_priority_scheduler_core.sv @@
// top level of the nonpreemptive priority scheduler
// depends on psch_pkg and psch_cell
//
// usage
// - each input transaction on s_* is one scheduler tick, optionally carrying
//   one arriving process (id, run time, priority)
// - each tick yields exactly one result transaction on m_*: finish report,
//   dispatch report, busy flag, queue occupancy and drop flag
// - the ready queue is a row of QUEUE_DEPTH cells kept sorted by ascending
//   priority number, equal priorities in arrival order; insert and pop of the
//   head both happen in the same cycle by shifting between neighbor cells
// - latency: the result of a tick is registered and appears the cycle after
//   the input transaction is taken
// - throughput: one tick per cycle; the next tick is taken while the result
//   register is being emptied, limited only by m_ready
// - when the receiver stalls, the held result blocks s_ready until taken
// - reset (aresetn low, synchronous) empties the queue, idles the processor
//   and drops any pending result; queue slot contents are not cleared
module nonpreemptive_priority_scheduler_core
    import psch_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_arrive_valid,
    input  logic [ID_W-1:0]     s_arrive_id,
    input  logic [RUN_W-1:0]    s_arrive_run_time,
    input  logic [PRIO_W-1:0]   s_arrive_priority,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_finished_valid,
    output logic [ID_W-1:0]     m_finished_id,
    output logic                m_dispatch_valid,
    output logic [ID_W-1:0]     m_dispatch_id,
    output logic                m_busy_res,
    output logic [QCOUNT_W-1:0] m_queue_count,
    output logic                m_dropped
);

    // control state
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             busy_reg,   busy_next;
    logic             m_valid_reg, m_valid_next;

    // processor state
    logic [ID_W-1:0]  running_id_reg,  running_id_next;
    logic [RUN_W-1:0] remaining_reg,   remaining_next;

    // result payload registers
    logic                fin_valid_reg;
    logic [ID_W-1:0]     fin_id_reg;
    logic                dis_valid_reg;
    logic [ID_W-1:0]     dis_id_reg;
    logic                busy_res_reg;
    logic [QCOUNT_W-1:0] qcount_reg;
    logic                dropped_reg;

    logic       tick;
    logic       full;
    logic       ins;
    logic       drop;
    logic       fin;
    logic       busy_mid;
    logic       nonempty;
    logic       pop;
    cell_ctrl_t ctrl;

    entry_t cell_entry     [QUEUE_DEPTH];
    entry_t cell_ins_entry [QUEUE_DEPTH];
    logic   cell_keep      [QUEUE_DEPTH];

    // result register frees up when empty or being taken this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign tick    = s_valid && s_ready;

    // step 1: insert unless full (a later pop in the same tick does not help)
    assign full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign ins  = s_arrive_valid && !full;
    assign drop = s_arrive_valid && full;

    // step 2 and 3: run down the current process, zero run time counts as one
    assign fin      = busy_reg && (remaining_reg <= RUN_W'(1));
    assign busy_mid = busy_reg && !fin;

    // step 4: dispatch the head of the queue as it stands after the insert
    assign nonempty = (count_reg != '0) || ins;
    assign pop      = !busy_mid && nonempty;

    always_comb begin
        ctrl.tick         = tick;
        ctrl.ins          = ins;
        ctrl.pop          = pop;
        ctrl.arrival.id   = s_arrive_id;
        ctrl.arrival.run  = s_arrive_run_time;
        ctrl.arrival.prio = s_arrive_priority;
    end

    // sorted queue, slot 0 is the head
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic   occ;
        logic   left_keep;
        entry_t left_entry;
        entry_t right_ins_entry;

        assign occ = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_head
            assign left_keep  = 1'b1;
            assign left_entry = '0;
        end else begin : g_body
            assign left_keep  = cell_keep[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign right_ins_entry = '0;
        end else begin : g_inner
            assign right_ins_entry = cell_ins_entry[i+1];
        end

        psch_cell u_cell (
            .aclk            (aclk),
            .ctrl            (ctrl),
            .occ             (occ),
            .left_keep       (left_keep),
            .left_entry      (left_entry),
            .right_ins_entry (right_ins_entry),
            .entry           (cell_entry[i]),
            .keep            (cell_keep[i]),
            .ins_entry       (cell_ins_entry[i])
        );
    end

    always_comb begin
        count_next      = count_reg;
        busy_next       = busy_reg;
        running_id_next = running_id_reg;
        remaining_next  = remaining_reg;
        m_valid_next    = m_valid_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (tick) begin
            m_valid_next = 1'b1;
            count_next   = count_reg + CNT_W'(ins) - CNT_W'(pop);
            if (pop) begin
                busy_next       = 1'b1;
                running_id_next = cell_ins_entry[0].id;
                remaining_next  = cell_ins_entry[0].run;
            end else if (busy_mid) begin
                busy_next      = 1'b1;
                remaining_next = remaining_reg - RUN_W'(1);
            end else begin
                busy_next      = 1'b0;
                remaining_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            busy_reg       <= 1'b0;
            running_id_reg <= '0;
            remaining_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            count_reg      <= count_next;
            busy_reg       <= busy_next;
            running_id_reg <= running_id_next;
            remaining_reg  <= remaining_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // result payload, loaded once per tick
    always_ff @(posedge aclk) begin
        if (tick) begin
            fin_valid_reg <= fin;
            fin_id_reg    <= fin ? running_id_reg : '0;
            dis_valid_reg <= pop;
            dis_id_reg    <= pop ? cell_ins_entry[0].id : '0;
            busy_res_reg  <= busy_next;
            qcount_reg    <= QCOUNT_W'(count_next);
            dropped_reg   <= drop;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_finished_valid = fin_valid_reg;
    assign m_finished_id    = fin_id_reg;
    assign m_dispatch_valid = dis_valid_reg;
    assign m_dispatch_id    = dis_id_reg;
    assign m_busy_res       = busy_res_reg;
    assign m_queue_count    = qcount_reg;
    assign m_dropped        = dropped_reg;

    // an idle processor never leaves work waiting in the queue
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (count_reg == '0))
        else $error("processor idle while queue holds processes");

    // occupancy never exceeds the number of cells
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // a drop is only reported for a tick that found the queue full
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        tick && s_arrive_valid && (count_reg != CNT_W'(QUEUE_DEPTH)) |=> !dropped_reg)
        else $error("drop reported with room in queue");

    // a dispatch report always comes with a busy processor
    a_dispatch_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dispatch_valid |-> m_busy_res)
        else $error("dispatch reported while idle");

    // a process with time left keeps the processor across a tick
    a_keep_running: assert property (@(posedge aclk) disable iff (!aresetn)
        tick && busy_reg && (remaining_reg > RUN_W'(1)) |=> busy_reg && !fin_valid_reg)
        else $error("running process lost before its time ran out");

endmodule

@@ hdl/psch_cell.sv @@
// one slot of the shift-register sorted ready queue
// depends on psch_pkg (entry_t, cell_ctrl_t)
module psch_cell
    import psch_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic       occ,              // slot holds a queued process
    input  logic       left_keep,        // left neighbor keeps its entry on insert
    input  entry_t     left_entry,       // left neighbor's stored entry
    input  entry_t     right_ins_entry,  // right neighbor's entry after insert
    output entry_t     entry,
    output logic       keep,
    output entry_t     ins_entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // an entry stays put when nothing is inserted or it sorts at or before the arrival
    assign keep = !ctrl.ins || (occ && (entry_reg.prio <= ctrl.arrival.prio));

    always_comb begin
        if (keep) begin
            ins_entry = entry_reg;
        end else if (left_keep) begin
            ins_entry = ctrl.arrival;
        end else begin
            ins_entry = left_entry;
        end
    end

    assign entry_next = ctrl.pop ? right_ins_entry : ins_entry;

    always_ff @(posedge aclk) begin
        if (ctrl.tick) begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule
